// File: rtl/core/i2cm_pkg.sv
// ============================================================================
// i2cm_pkg - shared types and constants of the I2C master bit engine
// Phase encoding, command codes, configuration register map and the
// structs that carry one tick, one result and the register set.
// ============================================================================
package i2cm_pkg;

    // Bus recovery clocks out this many SCL pulses with SDA released
    localparam int RECOVER_PULSES = 9;
    localparam int BIT_IDX_W      = 4;
    localparam logic [BIT_IDX_W-1:0] REC_LAST = BIT_IDX_W'(RECOVER_PULSES - 1);
    localparam logic [BIT_IDX_W-1:0] BYTE_LAST = BIT_IDX_W'(7);

    localparam int TICK_W    = 8;
    localparam int TMO_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int S_DATA_W  = 16;
    localparam int S_USER_W  = 4;
    localparam int M_DATA_W  = 16;

    localparam logic [TICK_W-1:0] PHASE_TICKS_RST   = 8'd2;
    localparam logic [TICK_W-1:0] SETTLE_TICKS_RST  = 8'd1;
    localparam logic [TICK_W-1:0] RECOVER_TICKS_RST = 8'd5;
    localparam logic [TMO_W-1:0]  ACK_TIMEOUT_RST   = 10'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_A,
        ST_START_B,
        ST_STOP_A,
        ST_STOP_B,
        ST_WR_LO,
        ST_WR_HI,
        ST_ACKW_REL,
        ST_ACKW_HI,
        ST_RD_LO,
        ST_RD_HI,
        ST_RDACK_LO,
        ST_RDACK_HI,
        ST_REC_HI,
        ST_REC_LO
    } phase_t;

    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_READ     = 3'd3,
        OP_WAIT_ACK = 3'd4,
        OP_RECOVER  = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_TICKS   = 3'd0,
        CFG_SETTLE_TICKS  = 3'd1,
        CFG_RECOVER_TICKS = 3'd2,
        CFG_ACK_TIMEOUT   = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              cmd_valid;
        logic [2:0]        op;
        logic [7:0]        tx_byte;
        logic              ack_send;
        logic              sda_in;
    } tick_t;

    typedef struct packed {
        logic              scl_drive;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [7:0]        rx_byte;
        logic              ack_error;
    } result_t;

    typedef struct packed {
        logic [TICK_W-1:0] phase_ticks;
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] recover_ticks;
        logic [TMO_W-1:0]  ack_timeout;
    } cfg_t;

endpackage

// File: rtl/core/i2cm_in_stage.sv
// ============================================================================
// i2cm_in_stage - input register of the tick stream
// Holds one accepted tick until the step logic consumes it.
// ============================================================================
module i2cm_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [i2cm_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [i2cm_pkg::S_USER_W-1:0] s_tuser,
    input  logic                          take,
    output logic                          tick_valid,
    output i2cm_pkg::tick_t               tick
);
    import i2cm_pkg::*;

    logic  valid_reg;
    tick_t tick_reg;

    assign s_tready   = !valid_reg || take;
    assign tick_valid = valid_reg;
    assign tick       = tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            tick_reg.cmd_valid <= s_tuser[0];
            tick_reg.op        <= s_tuser[3:1];
            tick_reg.tx_byte   <= s_tdata[7:0];
            tick_reg.ack_send  <= s_tdata[8];
            tick_reg.sda_in    <= s_tdata[9];
        end
    end

endmodule

// File: rtl/core/i2cm_step.sv
// ============================================================================
// i2cm_step - bit sequencer of the I2C master
// Applies one tick to the phase state and gives the levels after that tick.
// ============================================================================
module i2cm_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  i2cm_pkg::tick_t   tick,
    input  i2cm_pkg::cfg_t    cfg,
    output i2cm_pkg::result_t result
);
    import i2cm_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [TICK_W-1:0]      tick_cnt_reg, tick_cnt_next;
    logic [BIT_IDX_W-1:0]   bit_idx_reg, bit_idx_next;
    logic [7:0]             shift_reg, shift_next;
    logic [TMO_W-1:0]       tmo_reg, tmo_next;
    logic [TMO_W-1:0]       tmo_dec;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic                   ack_flag_reg, ack_flag_next;
    logic                   ack_choice_reg, ack_choice_next;
    logic [7:0]             rx_hold_reg, rx_hold_next;
    logic                   done_next;
    logic                   wait_more;

    assign wait_more = tick_cnt_reg > TICK_W'(1);
    assign tmo_dec   = tmo_reg - TMO_W'(1);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (phase_reg == ST_IDLE)
        begin
            if (tick.cmd_valid)
            begin
                case (op_t'(tick.op))
                    OP_START:    phase_next = ST_START_A;
                    OP_STOP:     phase_next = ST_STOP_A;
                    OP_WRITE:    phase_next = ST_WR_LO;
                    OP_READ:     phase_next = ST_RD_LO;
                    OP_WAIT_ACK: phase_next = ST_ACKW_REL;
                    OP_RECOVER:  phase_next = ST_REC_HI;
                    default:     phase_next = ST_IDLE;
                endcase
            end
        end
        else if (!wait_more)
        begin
            unique case (phase_reg)
                ST_START_A:  phase_next = ST_START_B;
                ST_STOP_A:   phase_next = ST_STOP_B;
                ST_WR_LO:    phase_next = ST_WR_HI;
                ST_WR_HI:    phase_next = (bit_idx_reg == '0) ? ST_IDLE : ST_WR_LO;
                ST_ACKW_REL: phase_next = ST_ACKW_HI;
                ST_ACKW_HI:  phase_next = (!tick.sda_in || tmo_dec == '0) ?
                                          ST_IDLE : ST_ACKW_HI;
                ST_RD_LO:    phase_next = ST_RD_HI;
                ST_RD_HI:    phase_next = (bit_idx_reg == '0) ? ST_RDACK_LO : ST_RD_LO;
                ST_RDACK_LO: phase_next = ST_RDACK_HI;
                ST_REC_HI:   phase_next = ST_REC_LO;
                ST_REC_LO:   phase_next = (bit_idx_reg == '0) ? ST_IDLE : ST_REC_HI;
                default:     phase_next = ST_IDLE;
            endcase
        end
    end

    // datapath and line levels
    always_comb
    begin
        tick_cnt_next   = tick_cnt_reg;
        bit_idx_next    = bit_idx_reg;
        shift_next      = shift_reg;
        tmo_next        = tmo_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_flag_next   = ack_flag_reg;
        ack_choice_next = ack_choice_reg;
        rx_hold_next    = rx_hold_reg;
        done_next       = 1'b0;
        if (phase_reg == ST_IDLE)
        begin
            if (tick.cmd_valid)
            begin
                case (op_t'(tick.op))
                    OP_START:
                    begin
                        scl_next      = 1'b1;
                        sda_next      = 1'b1;
                        tick_cnt_next = cfg.phase_ticks;
                    end
                    OP_STOP:
                    begin
                        scl_next      = 1'b0;
                        sda_next      = 1'b0;
                        tick_cnt_next = cfg.phase_ticks;
                    end
                    OP_WRITE:
                    begin
                        shift_next    = tick.tx_byte;
                        bit_idx_next  = BYTE_LAST;
                        scl_next      = 1'b0;
                        sda_next      = tick.tx_byte[7];
                        tick_cnt_next = cfg.phase_ticks;
                    end
                    OP_READ:
                    begin
                        shift_next      = '0;
                        bit_idx_next    = BYTE_LAST;
                        ack_choice_next = tick.ack_send;
                        scl_next        = 1'b0;
                        sda_next        = 1'b1;
                        tick_cnt_next   = cfg.phase_ticks;
                    end
                    OP_WAIT_ACK:
                    begin
                        tmo_next      = cfg.ack_timeout;
                        sda_next      = 1'b1;
                        tick_cnt_next = cfg.settle_ticks;
                    end
                    OP_RECOVER:
                    begin
                        bit_idx_next  = REC_LAST;
                        scl_next      = 1'b1;
                        sda_next      = 1'b1;
                        tick_cnt_next = cfg.recover_ticks;
                    end
                    default:
                    begin
                        tick_cnt_next = tick_cnt_reg;
                    end
                endcase
            end
        end
        else if (wait_more)
        begin
            tick_cnt_next = tick_cnt_reg - TICK_W'(1);
        end
        else
        begin
            unique case (phase_reg)
                ST_START_A:
                begin
                    sda_next      = 1'b0;
                    tick_cnt_next = cfg.phase_ticks;
                end
                ST_START_B:
                begin
                    scl_next      = 1'b0;
                    tick_cnt_next = '0;
                    done_next     = 1'b1;
                end
                ST_STOP_A:
                begin
                    scl_next      = 1'b1;
                    tick_cnt_next = cfg.phase_ticks;
                end
                ST_STOP_B:
                begin
                    sda_next      = 1'b1;
                    tick_cnt_next = '0;
                    done_next     = 1'b1;
                end
                ST_WR_LO:
                begin
                    scl_next      = 1'b1;
                    tick_cnt_next = cfg.phase_ticks;
                end
                ST_WR_HI:
                begin
                    scl_next = 1'b0;
                    if (bit_idx_reg == '0)
                    begin
                        sda_next      = 1'b1;
                        tick_cnt_next = '0;
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        bit_idx_next  = bit_idx_reg - BIT_IDX_W'(1);
                        shift_next    = {shift_reg[6:0], 1'b0};
                        sda_next      = shift_reg[6];
                        tick_cnt_next = cfg.phase_ticks;
                    end
                end
                ST_ACKW_REL:
                begin
                    scl_next      = 1'b1;
                    tick_cnt_next = cfg.settle_ticks;
                end
                ST_ACKW_HI:
                begin
                    if (!tick.sda_in)
                    begin
                        scl_next      = 1'b0;
                        ack_flag_next = 1'b0;
                        tick_cnt_next = '0;
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        tmo_next = tmo_dec;
                        if (tmo_dec == '0)
                        begin
                            scl_next      = 1'b0;
                            ack_flag_next = 1'b1;
                            tick_cnt_next = '0;
                            done_next     = 1'b1;
                        end
                        else
                        begin
                            tick_cnt_next = cfg.settle_ticks;
                        end
                    end
                end
                ST_RD_LO:
                begin
                    scl_next      = 1'b1;
                    shift_next    = {shift_reg[6:0], tick.sda_in};
                    tick_cnt_next = cfg.phase_ticks;
                end
                ST_RD_HI:
                begin
                    scl_next      = 1'b0;
                    tick_cnt_next = cfg.phase_ticks;
                    if (bit_idx_reg == '0)
                    begin
                        sda_next = !ack_choice_reg;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - BIT_IDX_W'(1);
                    end
                end
                ST_RDACK_LO:
                begin
                    scl_next      = 1'b1;
                    tick_cnt_next = cfg.phase_ticks;
                end
                ST_RDACK_HI:
                begin
                    scl_next      = 1'b0;
                    rx_hold_next  = shift_reg;
                    tick_cnt_next = '0;
                    done_next     = 1'b1;
                end
                ST_REC_HI:
                begin
                    scl_next      = 1'b0;
                    tick_cnt_next = cfg.recover_ticks;
                end
                ST_REC_LO:
                begin
                    scl_next = 1'b1;
                    if (bit_idx_reg == '0)
                    begin
                        sda_next      = 1'b1;
                        tick_cnt_next = '0;
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        bit_idx_next  = bit_idx_reg - BIT_IDX_W'(1);
                        tick_cnt_next = cfg.recover_ticks;
                    end
                end
                default:
                begin
                    tick_cnt_next = tick_cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ST_IDLE;
            tick_cnt_reg   <= '0;
            bit_idx_reg    <= '0;
            shift_reg      <= '0;
            tmo_reg        <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_flag_reg   <= 1'b0;
            ack_choice_reg <= 1'b0;
            rx_hold_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            tick_cnt_reg   <= tick_cnt_next;
            bit_idx_reg    <= bit_idx_next;
            shift_reg      <= shift_next;
            tmo_reg        <= tmo_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_flag_reg   <= ack_flag_next;
            ack_choice_reg <= ack_choice_next;
            rx_hold_reg    <= rx_hold_next;
        end
    end

    assign result.scl_drive = scl_next;
    assign result.sda_drive = sda_next;
    assign result.busy_res  = phase_next != ST_IDLE;
    assign result.done_res  = done_next;
    assign result.rx_byte   = rx_hold_next;
    assign result.ack_error = ack_flag_next;

endmodule

// File: rtl/core/i2c_master_bit_engine.sv
// ============================================================================
// i2c_master_bit_engine - tick-driven I2C master bit engine
// A tick request appears as a result request after the input register and then
// the result register. Throughput: one tick per cycle while the result side
// does not stall; the phase sequencer updates its state on each accepted tick.
// Reset (rst_n low, asynchronous): bus lines released, sequencer idle,
// registers at phase 2, settle 1, recover 5, ACK timeout 100.
// ============================================================================
module i2c_master_bit_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    // tick requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] tx_byte, [8] ack_send, [9] sda_in, [15:10] zero
    input  logic [i2cm_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] cmd_valid, [3:1] op
    input  logic [i2cm_pkg::S_USER_W-1:0]   s_tuser,
    // result requests
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] ack_error, [15:13] zero
    output logic [i2cm_pkg::M_DATA_W-1:0]   m_tdata,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import i2cm_pkg::*;

    cfg_t    cfg_reg;
    tick_t   tick;
    logic    tick_valid;
    logic    advance;
    result_t result;
    logic    out_valid_reg;
    result_t out_reg;

    // Register writes are always taken and land at once; issue them only while
    // no tick is in flight.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_ticks   <= PHASE_TICKS_RST;
            cfg_reg.settle_ticks  <= SETTLE_TICKS_RST;
            cfg_reg.recover_ticks <= RECOVER_TICKS_RST;
            cfg_reg.ack_timeout   <= ACK_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // drop writes to indexes past the register map
            case (cfg_idx_t'(cfg_index))
                CFG_PHASE_TICKS:   cfg_reg.phase_ticks   <= cfg_data[TICK_W-1:0];
                CFG_SETTLE_TICKS:  cfg_reg.settle_ticks  <= cfg_data[TICK_W-1:0];
                CFG_RECOVER_TICKS: cfg_reg.recover_ticks <= cfg_data[TICK_W-1:0];
                CFG_ACK_TIMEOUT:   cfg_reg.ack_timeout   <= cfg_data[TMO_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Advance the sequencer when a tick waits and the result slot is free or
    // being emptied this cycle; otherwise hold both the tick and the state.
    assign advance = tick_valid && (!out_valid_reg || m_tready);

    i2cm_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (advance),
        .tick_valid (tick_valid),
        .tick       (tick)
    );

    i2cm_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .tick    (tick),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result register: parts the sequencer from the downstream stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= tick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.ack_error, out_reg.rx_byte, out_reg.done_res,
                       out_reg.busy_res, out_reg.sda_drive, out_reg.scl_drive};

endmodule

// File: rtl/core/i2cm_checker.sv
// ============================================================================
// i2cm_checker - port-level checks of the I2C master bit engine
// Watches the stream ports and flags handshake and sequencing slips.
// ============================================================================
module i2cm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [i2cm_pkg::M_DATA_W-1:0] m_tdata
);
    import i2cm_pkg::*;

    // a completing tick never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
        else $error("done and busy reported together");

    // input stalls only while a result waits on a stalled output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/i2cm_line_tracker.sv
// ============================================================================
// i2cm_line_tracker - bus level tracker of the I2C master bit engine
// Follows every accepted tick and register write, works out the SCL/SDA
// levels, status flags and received byte that each tick must give, and
// compares them field by field with the result requests of the engine.
// ============================================================================
module i2cm_line_tracker
    import i2cm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [S_USER_W-1:0]   s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    err_cnt,
    output int                    pending,
    output logic                  eng_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copy
    logic [TICK_W-1:0] c_phase, c_settle, c_recover;
    logic [TMO_W-1:0]  c_tmo;

    // sequencer copy
    phase_t               ph;
    logic [TICK_W-1:0]    tcnt;
    logic [BIT_IDX_W-1:0] bidx;
    logic [7:0]           shreg;
    logic [TMO_W-1:0]     tmo;
    logic                 scl, sda_o, ackf, ackc, done_now;
    logic [7:0]           rxh;

    result_t level_q[$];

    task automatic close_command();
        ph       = ST_IDLE;
        tcnt     = '0;
        done_now = 1'b1;
    endtask

    // One tick of the sequencer: a command is taken only while idle
    task automatic step_bus_engine(input logic cv, input logic [2:0] opc,
                                   input logic [7:0] txb, input logic acks,
                                   input logic sda, output result_t r);
        done_now = 1'b0;
        if (ph == ST_IDLE) begin
            if (cv) begin
                case (opc)
                    OP_START: begin
                        scl = 1'b1; sda_o = 1'b1; ph = ST_START_A; tcnt = c_phase;
                    end
                    OP_STOP: begin
                        scl = 1'b0; sda_o = 1'b0; ph = ST_STOP_A; tcnt = c_phase;
                    end
                    OP_WRITE: begin
                        shreg = txb; bidx = BYTE_LAST;
                        scl = 1'b0; sda_o = txb[7]; ph = ST_WR_LO; tcnt = c_phase;
                    end
                    OP_READ: begin
                        shreg = '0; bidx = BYTE_LAST; ackc = acks;
                        sda_o = 1'b1; scl = 1'b0; ph = ST_RD_LO; tcnt = c_phase;
                    end
                    OP_WAIT_ACK: begin
                        tmo = c_tmo; sda_o = 1'b1; ph = ST_ACKW_REL; tcnt = c_settle;
                    end
                    OP_RECOVER: begin
                        bidx = REC_LAST; sda_o = 1'b1; scl = 1'b1;
                        ph = ST_REC_HI; tcnt = c_recover;
                    end
                    default: ;
                endcase
            end
        end
        else if (tcnt > 1) begin
            tcnt = tcnt - 1'b1;
        end
        else begin
            case (ph)
                ST_START_A: begin sda_o = 1'b0; ph = ST_START_B; tcnt = c_phase; end
                ST_START_B: begin scl = 1'b0; close_command(); end
                ST_STOP_A:  begin scl = 1'b1; ph = ST_STOP_B; tcnt = c_phase; end
                ST_STOP_B:  begin sda_o = 1'b1; close_command(); end
                ST_WR_LO:   begin scl = 1'b1; ph = ST_WR_HI; tcnt = c_phase; end
                ST_WR_HI: begin
                    scl = 1'b0;
                    if (bidx == 0) begin
                        sda_o = 1'b1;
                        close_command();
                    end
                    else begin
                        bidx  = bidx - 1'b1;
                        shreg = shreg << 1;
                        sda_o = shreg[7];
                        ph    = ST_WR_LO;
                        tcnt  = c_phase;
                    end
                end
                ST_ACKW_REL: begin scl = 1'b1; ph = ST_ACKW_HI; tcnt = c_settle; end
                ST_ACKW_HI: begin
                    if (!sda) begin
                        scl = 1'b0; ackf = 1'b0; close_command();
                    end
                    else begin
                        // a zero limit wraps the counter, giving 1024 samples
                        tmo = tmo - 1'b1;
                        if (tmo == 0) begin
                            scl = 1'b0; ackf = 1'b1; close_command();
                        end
                        else begin
                            tcnt = c_settle;
                        end
                    end
                end
                ST_RD_LO: begin
                    scl = 1'b1; shreg = {shreg[6:0], sda}; ph = ST_RD_HI; tcnt = c_phase;
                end
                ST_RD_HI: begin
                    scl  = 1'b0;
                    tcnt = c_phase;
                    if (bidx == 0) begin
                        sda_o = ~ackc;
                        ph    = ST_RDACK_LO;
                    end
                    else begin
                        bidx = bidx - 1'b1;
                        ph   = ST_RD_LO;
                    end
                end
                ST_RDACK_LO: begin scl = 1'b1; ph = ST_RDACK_HI; tcnt = c_phase; end
                ST_RDACK_HI: begin scl = 1'b0; rxh = shreg; close_command(); end
                ST_REC_HI:   begin scl = 1'b0; ph = ST_REC_LO; tcnt = c_recover; end
                ST_REC_LO: begin
                    scl = 1'b1;
                    if (bidx == 0) begin
                        sda_o = 1'b1;
                        close_command();
                    end
                    else begin
                        bidx = bidx - 1'b1;
                        ph   = ST_REC_HI;
                        tcnt = c_recover;
                    end
                end
                default: ph = ST_IDLE;
            endcase
        end
        r.scl_drive = scl;
        r.sda_drive = sda_o;
        r.busy_res  = (ph != ST_IDLE);
        r.done_res  = done_now;
        r.rx_byte   = rxh;
        r.ack_error = ackf;
    endtask

    task automatic cmp_field(input string tag, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            err_cnt++;
            $display("@%0t %s mismatch: expected %0d, got %0d", $time, tag, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want, got;
        if (!rst_n) begin
            c_phase   = PHASE_TICKS_RST;
            c_settle  = SETTLE_TICKS_RST;
            c_recover = RECOVER_TICKS_RST;
            c_tmo     = ACK_TIMEOUT_RST;
            ph        = ST_IDLE;
            tcnt      = '0;
            bidx      = '0;
            shreg     = '0;
            tmo       = '0;
            scl       = 1'b1;
            sda_o     = 1'b1;
            ackf      = 1'b0;
            ackc      = 1'b0;
            rxh       = '0;
            done_now  = 1'b0;
            err_cnt   = 0;
            level_q.delete();
            pending  <= 0;
            eng_busy <= 1'b0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PHASE_TICKS:   c_phase   = cfg_data[TICK_W-1:0];
                    CFG_SETTLE_TICKS:  c_settle  = cfg_data[TICK_W-1:0];
                    CFG_RECOVER_TICKS: c_recover = cfg_data[TICK_W-1:0];
                    CFG_ACK_TIMEOUT:   c_tmo     = cfg_data[TMO_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                step_bus_engine(s_tuser[0], s_tuser[3:1], s_tdata[7:0], s_tdata[8],
                                s_tdata[9], want);
                level_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.scl_drive = m_tdata[0];
                got.sda_drive = m_tdata[1];
                got.busy_res  = m_tdata[2];
                got.done_res  = m_tdata[3];
                got.rx_byte   = m_tdata[11:4];
                got.ack_error = m_tdata[12];
                if (level_q.size() == 0) begin
                    err_cnt++;
                    $display("@%0t result with no tick pending: expected none, got 0x%04h",
                             $time, m_tdata);
                end
                else begin
                    want = level_q.pop_front();
                    cmp_field("scl_drive", want.scl_drive, got.scl_drive);
                    cmp_field("sda_drive", want.sda_drive, got.sda_drive);
                    cmp_field("busy_res",  want.busy_res,  got.busy_res);
                    cmp_field("done_res",  want.done_res,  got.done_res);
                    cmp_field("rx_byte",   want.rx_byte,   got.rx_byte);
                    cmp_field("ack_error", want.ack_error, got.ack_error);
                end
            end
            pending  <= level_q.size();
            eng_busy <= (ph != ST_IDLE);
        end
    end

endmodule

// File: bench/tb_i2c_master_bit_engine.sv
// ============================================================================
// tb_i2c_master_bit_engine - stimulus and verdict for the I2C master engine
// Drives tick requests carrying start, stop, write, read, ACK wait and bus
// recovery commands with random SDA levels, random gaps on the tick side and
// random stalls on the result side, and rewrites the timing registers between
// phases. The line tracker beside the engine predicts and checks each result.
// ============================================================================
module tb_i2c_master_bit_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    // total tick requests to send, directed ones included
    localparam int TOTAL_TICKS  = 1850;
    localparam int DRAIN_CYCLES = 8;
    // command codes and register indexes the engine has to ignore
    localparam logic [2:0] OP_HOLE_LO = 3'(OP_RECOVER + 1);
    localparam logic [2:0] OP_HOLE_HI = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_LO = CFG_IDX_W'(CFG_ACK_TIMEOUT + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_HI = '1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [S_USER_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   err_cnt;
    int   pending;
    logic eng_busy;

    // no gaps and no stalls while set
    logic quiet = 1'b0;
    int   stall_left = 0;
    int   cycle_cnt = 0;
    int   tick_cnt = 0;

    i2c_master_bit_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2cm_line_tracker i_line_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .err_cnt   (err_cnt),
        .pending   (pending),
        .eng_busy  (eng_busy)
    );

    always #1 clk = ~clk;

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic sda_pick(input int pct_high);
        return $urandom_range(99) < pct_high;
    endfunction

    // Stall the result side at random; drop ready for the chosen gap
    always @(posedge clk) begin
        int gap;
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else begin
            gap = quiet ? 0 : pick_gap();
            if (gap == 0) begin
                m_tready <= 1'b1;
            end
            else begin
                m_tready   <= 1'b0;
                stall_left <= gap - 1;
            end
        end
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one tick request, after an optional gap, and hold it until taken.
    // Valid stays high between back-to-back requests.
    task automatic send_tick(input logic cv, input logic [2:0] opc, input logic [7:0] txb,
                             input logic acks, input logic sda);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {opc, cv};
        s_tdata  <= {6'b0, sda, acks, txb};
        do @(posedge clk); while (!s_tready);
        tick_cnt++;
    endtask

    // Issue one command, then advance with filler ticks until the engine is
    // idle again. Filler ticks carry a stray command now and then, which the
    // engine must ignore while busy (the completion tick included). The busy
    // view lags one tick, so a stray command may land right after completion.
    task automatic run_cmd(input logic [2:0] opc, input logic [7:0] txb, input logic acks,
                           input int pct_high, input int noise_pct);
        send_tick(1'b1, opc, txb, acks, sda_pick(pct_high));
        do begin
            send_tick($urandom_range(99) < noise_pct, 3'($urandom_range(OP_HOLE_HI)),
                      8'($urandom), 1'($urandom_range(1)), sda_pick(pct_high));
        end while (eng_busy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Bring the engine to idle, let every result drain, then rewrite all
    // registers. The unused upper data bits of the 8-bit registers and a
    // write to an unused index go along as noise.
    task automatic set_regs(input int p, input int s, input int r, input int t);
        do begin
            send_tick(1'b0, 3'($urandom_range(OP_HOLE_HI)), 8'($urandom),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
        end while (eng_busy);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        write_reg(CFG_PHASE_TICKS,   {2'($urandom_range(3)), 8'(p)});
        write_reg(CFG_SETTLE_TICKS,  {2'($urandom_range(3)), 8'(s)});
        write_reg(CFG_RECOVER_TICKS, {2'($urandom_range(3)), 8'(r)});
        write_reg(CFG_ACK_TIMEOUT,   CFG_DATA_W'(t));
        write_reg(CFG_IDX_W'($urandom_range(CFG_HOLE_HI, CFG_HOLE_LO)), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int n_cmds, pct, pick;
        int p, s, r, t;
        logic [2:0] opc;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset timing, every command, byte extremes, ACK and NACK,
        // ACK wait success and timeout, ignored codes and commands while busy
        run_cmd(OP_START,    8'h00, 1'b0, 50, 0);
        run_cmd(OP_WRITE,    8'h00, 1'b0, 50, 0);
        run_cmd(OP_WRITE,    8'hFF, 1'b1, 50, 0);
        run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 0, 0);
        run_cmd(OP_READ,     8'h00, 1'b1, 50, 0);
        run_cmd(OP_READ,     8'hFF, 1'b0, 100, 0);
        run_cmd(OP_READ,     8'h00, 1'b1, 0, 0);
        run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 100, 0);
        run_cmd(OP_WRITE,    8'hA5, 1'b0, 50, 30);
        run_cmd(OP_HOLE_LO,  8'hFF, 1'b1, 50, 0);
        run_cmd(OP_HOLE_HI,  8'h00, 1'b0, 50, 0);
        run_cmd(OP_RECOVER,  8'h00, 1'b0, 50, 0);
        run_cmd(OP_STOP,     8'h00, 1'b0, 50, 0);

        // Zero registers: one tick per step, ACK wait counter wraps
        set_regs(0, 0, 0, 0);
        run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 100, 0);
        run_cmd(OP_WRITE,    8'h5A, 1'b0, 50, 0);
        run_cmd(OP_READ,     8'h00, 1'b1, 50, 0);
        run_cmd(OP_RECOVER,  8'h00, 1'b0, 50, 0);
        run_cmd(OP_STOP,     8'h00, 1'b0, 50, 0);

        // Fastest timing, ACK timeout at the top of its 10-bit range
        set_regs(1, 1, 1, 1023);
        run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 99, 0);

        // Random phases: short timing in most, random commands and SDA levels
        while (tick_cnt < TOTAL_TICKS) begin
            p = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
            s = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
            r = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
            t = ($urandom_range(9) == 0) ? $urandom_range(80, 17) : $urandom_range(12, 1);
            set_regs(p, s, r, t);
            quiet  <= ($urandom_range(3) == 0);
            n_cmds = $urandom_range(12, 4);
            repeat (n_cmds) begin
                pick = $urandom_range(99);
                if (pick < 5)
                    opc = 3'($urandom_range(OP_HOLE_HI, OP_HOLE_LO));
                else
                    opc = 3'($urandom_range(OP_RECOVER, OP_START));
                case ($urandom_range(3))
                    0:       pct = 0;
                    1:       pct = 40;
                    2:       pct = 85;
                    default: pct = 100;
                endcase
                run_cmd(opc, 8'($urandom), 1'($urandom_range(1)), pct, 10);
            end
        end

        // Drain: wait for every result, then print the verdict
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_in_stage.sv
rtl/core/i2cm_step.sv
rtl/core/i2c_master_bit_engine.sv
rtl/core/i2cm_checker.sv
bench/i2cm_line_tracker.sv
bench/tb_i2c_master_bit_engine.sv
